FILE: design/a85_pkg.sv
// ----------------------------------------------------------------------------
// a85_pkg: shared types and constants for the Ascii85 decoder
// Item and result layouts, the group job passed from front to back,
// result status codes and the padding scale table.
// ----------------------------------------------------------------------------
package a85_pkg;

	// Character codes
	localparam logic [7:0] CH_FIRST   = 8'd33;  // '!'
	localparam logic [7:0] CH_LAST    = 8'd117; // 'u'
	localparam logic [7:0] CH_ZERO    = 8'd122; // 'z'
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_CR      = 8'd13;
	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [31:0] DIGIT_BASE = 32'd33;
	localparam logic [19:0] RADIX      = 20'd85;

	// Characters in a complete group, minus one
	localparam logic [2:0] GROUP_LAST = 3'd4;

	// Default depth of the job queue between front and back
	localparam int JOB_DEPTH = 4;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_CHAR   = 2'd1,
		ST_Z_IN_GROUP = 2'd2,
		ST_LONE       = 2'd3
	} status_t;

	// One input request
	typedef struct packed {
		logic [7:0] symbol;
		logic       end_of_stream;
	} in_item_t;

	// One result
	typedef struct packed {
		logic [7:0] data_byte;
		logic [1:0] status;
		logic       last;
	} out_item_t;

	// One decoded group: up to four bytes, or a single error result
	typedef struct packed {
		logic [31:0] value;     // zero for error jobs
		logic [1:0]  nbytes_m1; // results minus one
		status_t     status;
	} job_t;

	// Padding a group of cnt digits with 'u' up to five digits is
	// v*85^k + (85^k - 1), k = 5 - cnt. Returns 85^k.
	function automatic logic [19:0] pad_scale(input logic [2:0] cnt);
		logic [19:0] s;
		begin
			case (cnt)
				3'd2: s = 20'd614125;
				3'd3: s = 20'd7225;
				3'd4: s = 20'd85;
				default: s = 20'd1;
			endcase
			return s;
		end
	endfunction

endpackage

FILE: design/a85_front.sv
// ----------------------------------------------------------------------------
// a85_front: character classification and group accumulation
// Takes one request a cycle unless full, folds digits into the base-85 group
// and hands completed groups and error results to the job queue.
// ----------------------------------------------------------------------------
module a85_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  a85_pkg::in_item_t  item,
	output logic               job_push,
	output a85_pkg::job_t      job,
	input  logic               job_full
);

	logic [31:0] group_q;
	logic [2:0]  count_q;
	logic        bad_q;

	logic        accept;
	logic        is_space;
	logic        out_of_range;
	logic [19:0] mul_b;
	logic [31:0] addend;
	logic [31:0] product;
	logic [31:0] mac;

	logic        clear;
	logic        store;
	logic [31:0] group_d;
	logic        bad_d;

	assign full   = job_full;
	assign accept = push && !job_full;

	// Character classes
	always_comb begin
		is_space     = item.symbol inside {[a85_pkg::CH_TAB:a85_pkg::CH_CR], a85_pkg::CH_SPACE};
		out_of_range = !(item.symbol inside {[a85_pkg::CH_FIRST:a85_pkg::CH_LAST]});
	end

	// Shared multiply-add: digit fold, or padding of a partial group
	always_comb begin
		if (item.end_of_stream) begin
			mul_b  = a85_pkg::pad_scale(count_q);
			addend = {12'd0, mul_b} - 32'd1;
		end else begin
			mul_b  = a85_pkg::RADIX;
			addend = {24'd0, item.symbol} - a85_pkg::DIGIT_BASE;
		end
		product = group_q * {12'd0, mul_b};
		mac     = product + addend;
	end

	// Decision per request
	always_comb begin
		job_push      = 1'b0;
		job.value     = 32'd0;
		job.nbytes_m1 = 2'd0;
		job.status    = a85_pkg::ST_OK;
		clear         = 1'b0;
		store         = 1'b0;
		bad_d         = bad_q | out_of_range;
		group_d       = mac;
		if (accept) begin
			if (item.end_of_stream) begin
				if (count_q == 3'd1) begin
					job_push   = 1'b1;
					job.status = a85_pkg::ST_LONE;
					clear      = 1'b1;
				end else if (count_q != 3'd0) begin
					job_push = 1'b1;
					clear    = 1'b1;
					if (bad_q) begin
						job.status = a85_pkg::ST_BAD_CHAR;
					end else begin
						job.value     = mac;
						job.nbytes_m1 = 2'(count_q - 3'd2);
					end
				end
			end else if (is_space) begin
				// skipped
			end else if (item.symbol == a85_pkg::CH_ZERO) begin
				job_push = 1'b1;
				clear    = 1'b1;
				if (count_q != 3'd0) begin
					job.status = a85_pkg::ST_Z_IN_GROUP;
				end else begin
					job.nbytes_m1 = 2'd3;
				end
			end else if (count_q == a85_pkg::GROUP_LAST) begin
				// fifth digit completes the group
				job_push = 1'b1;
				clear    = 1'b1;
				if (bad_d) begin
					job.status = a85_pkg::ST_BAD_CHAR;
				end else begin
					job.value     = mac;
					job.nbytes_m1 = 2'd3;
				end
			end else begin
				store = 1'b1;
			end
		end
	end

	// Group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q <= 32'd0;
			count_q <= 3'd0;
			bad_q   <= 1'b0;
		end else if (clear) begin
			group_q <= 32'd0;
			count_q <= 3'd0;
			bad_q   <= 1'b0;
		end else if (store) begin
			group_q <= group_d;
			count_q <= count_q + 3'd1;
			bad_q   <= bad_d;
		end
	end

endmodule

FILE: design/a85_jobq.sv
// ----------------------------------------------------------------------------
// a85_jobq: job queue between front and back
// Small circular buffer of decoded group jobs.
// ----------------------------------------------------------------------------
module a85_jobq #(
	parameter int DEPTH = a85_pkg::JOB_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  a85_pkg::job_t wr_job,
	output logic          full,
	input  logic          rd_en,
	output a85_pkg::job_t rd_job,
	output logic          empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	a85_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full   = (count_q == CNT_FULL);
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_job = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: design/a85_back.sv
// ----------------------------------------------------------------------------
// a85_back: result serializer
// Holds the current job and hands out its bytes, most significant first,
// one result per pop.
// ----------------------------------------------------------------------------
module a85_back (
	input  logic               clk,
	input  logic               arst_n,
	input  a85_pkg::job_t      head,
	input  logic               head_empty,
	output logic               head_pop,
	output logic               empty,
	input  logic               pop,
	output a85_pkg::out_item_t result
);

	a85_pkg::job_t job_q;
	logic [1:0]    idx_q;
	logic          busy_q;
	logic          is_last;
	logic          take;

	assign is_last  = (idx_q == job_q.nbytes_m1);
	assign empty    = !busy_q;
	assign take     = !busy_q || (pop && is_last);
	assign head_pop = take && !head_empty;

	// Result fields from the held job
	always_comb begin
		case (idx_q)
			2'd0:    result.data_byte = job_q.value[31:24];
			2'd1:    result.data_byte = job_q.value[23:16];
			2'd2:    result.data_byte = job_q.value[15:8];
			default: result.data_byte = job_q.value[7:0];
		endcase
		result.status = job_q.status;
		result.last   = is_last;
	end

	// Job payload
	always_ff @(posedge clk) begin
		if (head_pop) begin
			job_q <= head;
		end
	end

	// Byte index and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (take) begin
			busy_q <= !head_empty;
			idx_q  <= 2'd0;
		end else if (pop) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

FILE: design/ascii85_decoder.sv
// ----------------------------------------------------------------------------
// ascii85_decoder: streaming Ascii85 decoder
// Decodes one text character per request into bytes or error results.
// ----------------------------------------------------------------------------
// The decoder takes one character (or an end-of-stream mark) per clock while
// full is low; full rises only when the job queue of JOB_DEPTH decoded groups
// is taken up. Each completed group, 'z', flush or error becomes one job that
// gives one to four results, one per clock on pop, so a stream of groups runs
// at up to four results per five characters and the pop side sets the
// sustained rate. A result reaches the ports through the job queue, which
// takes the job from the group multiply-add, and then the output register
// of the back end, which loads it once the previous job is done.
// Whitespace and pending digits give no result.
module ascii85_decoder #(
	parameter int JOB_DEPTH = a85_pkg::JOB_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  a85_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output a85_pkg::out_item_t result
);

	logic          job_push;
	a85_pkg::job_t job;
	logic          job_full;
	a85_pkg::job_t head;
	logic          head_empty;
	logic          head_pop;

	// Front: classify and accumulate
	a85_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.job_push (job_push),
		.job      (job),
		.job_full (job_full)
	);

	// Queue of decoded groups
	a85_jobq #(
		.DEPTH (JOB_DEPTH)
	) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_job (job),
		.full   (job_full),
		.rd_en  (head_pop),
		.rd_job (head),
		.empty  (head_empty)
	);

	// Back: serialize results
	a85_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

FILE: dv/tb_ascii85_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ascii85_decoder: self-checking testbench for the Ascii85 decoder
// A short table of directed requests and then random character streams are
// pushed through the decoder. An in-bench group decoder predicts each result
// not typed in a row; each popped result is compared field by field in order.
// ----------------------------------------------------------------------------
module tb_ascii85_decoder;

	localparam int          WATCHDOG_LIMIT = 5000;
	localparam int          TAIL_CYCLES    = 16;
	localparam int          LONG_HOLD      = 400;
	localparam logic [31:0] BASE85         = 32'd85;
	localparam logic [31:0] PAD_DIGIT      = 32'd84;  // 'u'

	// One stimulus row; fixed rows carry their results typed in
	typedef struct packed {
		logic [7:0]       symbol;
		logic             eos;
		logic             fixed;
		logic [2:0]       nres;
		logic [7:0]       byte_v;
		a85_pkg::status_t st;
	} dir_row_t;

	localparam int N_DIRECTED = 25;
	localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		// flush with nothing pending, blanks
		'{8'h00,             1'b1, 1'b1, 3'd0, 8'h00, a85_pkg::ST_OK},
		'{a85_pkg::CH_SPACE, 1'b0, 1'b1, 3'd0, 8'h00, a85_pkg::ST_OK},
		'{a85_pkg::CH_TAB,   1'b0, 1'b1, 3'd0, 8'h00, a85_pkg::ST_OK},
		// 'z' shorthand outside a group
		'{a85_pkg::CH_ZERO,  1'b0, 1'b1, 3'd4, 8'h00, a85_pkg::ST_OK},
		// lowest digits: a zero group
		'{a85_pkg::CH_FIRST, 1'b0, 1'b1, 3'd0, 8'h00, a85_pkg::ST_OK},
		'{a85_pkg::CH_FIRST, 1'b0, 1'b1, 3'd0, 8'h00, a85_pkg::ST_OK},
		'{a85_pkg::CH_FIRST, 1'b0, 1'b1, 3'd0, 8'h00, a85_pkg::ST_OK},
		'{a85_pkg::CH_FIRST, 1'b0, 1'b1, 3'd0, 8'h00, a85_pkg::ST_OK},
		'{a85_pkg::CH_FIRST, 1'b0, 1'b1, 3'd4, 8'h00, a85_pkg::ST_OK},
		// highest digits: the group wraps past 2^32
		'{a85_pkg::CH_LAST,  1'b0, 1'b0, 3'd0, 8'h00, a85_pkg::ST_OK},
		'{a85_pkg::CH_LAST,  1'b0, 1'b0, 3'd0, 8'h00, a85_pkg::ST_OK},
		'{a85_pkg::CH_LAST,  1'b0, 1'b0, 3'd0, 8'h00, a85_pkg::ST_OK},
		'{a85_pkg::CH_LAST,  1'b0, 1'b0, 3'd0, 8'h00, a85_pkg::ST_OK},
		'{a85_pkg::CH_LAST,  1'b0, 1'b0, 3'd0, 8'h00, a85_pkg::ST_OK},
		// 'z' inside a group
		'{8'h41,             1'b0, 1'b1, 3'd0, 8'h00, a85_pkg::ST_OK},
		'{a85_pkg::CH_ZERO,  1'b0, 1'b1, 3'd1, 8'h00, a85_pkg::ST_Z_IN_GROUP},
		// lone final character wins over a bad character
		'{8'h00,             1'b0, 1'b1, 3'd0, 8'h00, a85_pkg::ST_OK},
		'{8'h00,             1'b1, 1'b1, 3'd1, 8'h00, a85_pkg::ST_LONE},
		// bad character in a flushed partial group
		'{8'hFF,             1'b0, 1'b1, 3'd0, 8'h00, a85_pkg::ST_OK},
		'{8'h42,             1'b0, 1'b1, 3'd0, 8'h00, a85_pkg::ST_OK},
		'{8'h00,             1'b1, 1'b1, 3'd1, 8'h00, a85_pkg::ST_BAD_CHAR},
		// two-digit partial group, flush symbol is ignored
		'{8'h41,             1'b0, 1'b0, 3'd0, 8'h00, a85_pkg::ST_OK},
		'{8'h35,             1'b0, 1'b0, 3'd0, 8'h00, a85_pkg::ST_OK},
		'{a85_pkg::CH_ZERO,  1'b1, 1'b0, 3'd0, 8'h00, a85_pkg::ST_OK},
		'{8'hFF,             1'b1, 1'b1, 3'd0, 8'h00, a85_pkg::ST_OK}
	};

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               push   = 1'b0;
	logic               full;
	a85_pkg::in_item_t  item   = '0;
	logic               empty;
	logic               pop    = 1'b0;
	a85_pkg::out_item_t result;

	// Group decoder state
	logic [31:0]        grp_value;
	logic [2:0]         grp_count;
	logic               grp_bad;
	a85_pkg::out_item_t burst [4];
	int                 burst_len;

	a85_pkg::out_item_t due_results [$];
	int                 errors       = 0;
	int                 snd_idle_pct = 0;
	int                 rcv_idle_pct = 0;
	int                 rcv_hold     = 0;
	int                 quiet_cycles = 0;

	ascii85_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #10 clk = ~clk;

	function automatic logic is_blank(input logic [7:0] c);
		return (c >= a85_pkg::CH_TAB && c <= a85_pkg::CH_CR) || c == a85_pkg::CH_SPACE;
	endfunction

	function automatic void clear_group();
		grp_value = '0;
		grp_count = '0;
		grp_bad   = 1'b0;
	endfunction

	function automatic void emit_error(input a85_pkg::status_t st);
		burst[0].data_byte = 8'h00;
		burst[0].status    = st;
		burst[0].last      = 1'b1;
		burst_len          = 1;
		clear_group();
	endfunction

	// Bytes go out most significant first
	function automatic void emit_bytes(input logic [31:0] v, input int n);
		int k;
		for (k = 0; k < n; k++) begin
			burst[k].data_byte = v[31 - 8 * k -: 8];
			burst[k].status    = a85_pkg::ST_OK;
			burst[k].last      = (k == n - 1);
		end
		burst_len = n;
		clear_group();
	endfunction

	// Results caused by one accepted request, left in burst
	function automatic void decode_request(input a85_pkg::in_item_t req);
		logic [31:0] v;
		int          n;
		burst_len = 0;
		if (req.end_of_stream) begin
			if (grp_count == 3'd0)
				return;
			if (grp_count == 3'd1) begin
				emit_error(a85_pkg::ST_LONE);
				return;
			end
			if (grp_bad) begin
				emit_error(a85_pkg::ST_BAD_CHAR);
				return;
			end
			// pad with 'u' up to five digits
			v = grp_value;
			for (n = int'(grp_count); n < 5; n++)
				v = v * BASE85 + PAD_DIGIT;
			emit_bytes(v, int'(grp_count) - 1);
			return;
		end
		if (is_blank(req.symbol))
			return;
		if (req.symbol == a85_pkg::CH_ZERO) begin
			if (grp_count != 3'd0)
				emit_error(a85_pkg::ST_Z_IN_GROUP);
			else
				emit_bytes('0, 4);
			return;
		end
		if (req.symbol < a85_pkg::CH_FIRST || req.symbol > a85_pkg::CH_LAST)
			grp_bad = 1'b1;
		grp_value = grp_value * BASE85 + {24'd0, req.symbol} - a85_pkg::DIGIT_BASE;
		grp_count = grp_count + 3'd1;
		if (grp_count == 3'd5) begin
			if (grp_bad)
				emit_error(a85_pkg::ST_BAD_CHAR);
			else
				emit_bytes(grp_value, 4);
		end
	endfunction

	function automatic dir_row_t plain(input logic [7:0] sym, input logic eos);
		dir_row_t r;
		r        = '0;
		r.symbol = sym;
		r.eos    = eos;
		return r;
	endfunction

	function automatic logic [7:0] pick_digit();
		case ($urandom_range(7))
			0:       return a85_pkg::CH_FIRST;
			1:       return a85_pkg::CH_LAST;
			default: return 8'($urandom_range(a85_pkg::CH_LAST, a85_pkg::CH_FIRST));
		endcase
	endfunction

	function automatic logic [7:0] pick_blank();
		int k;
		k = $urandom_range(5);
		if (k == 5)
			return a85_pkg::CH_SPACE;
		return a85_pkg::CH_TAB + 8'(k);
	endfunction

	// Any code that is neither a digit, 'z' nor whitespace
	function automatic logic [7:0] pick_bad();
		logic [7:0] s;
		do
			s = 8'($urandom_range(255));
		while ((s >= a85_pkg::CH_FIRST && s <= a85_pkg::CH_LAST) ||
			s == a85_pkg::CH_ZERO || is_blank(s));
		return s;
	endfunction

	// Offer one request, wait for it to be taken, log what it owes
	task automatic send_req(input dir_row_t row);
		a85_pkg::in_item_t  req;
		a85_pkg::out_item_t owed;
		int                 k;
		req.symbol        = row.symbol;
		req.end_of_stream = row.eos;
		while ($urandom_range(99) < snd_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= req;
		do
			@(posedge clk);
		while (full);
		decode_request(req);
		if (row.fixed) begin
			for (k = 0; k < int'(row.nres); k++) begin
				owed.data_byte = row.byte_v;
				owed.status    = row.st;
				owed.last      = (k == int'(row.nres) - 1);
				due_results.insert(due_results.size(), owed);
			end
		end else begin
			for (k = 0; k < burst_len; k++)
				due_results.insert(due_results.size(), burst[k]);
		end
	endtask

	// Sender goes quiet until every owed result has come back
	task automatic drain();
		push <= 1'b0;
		do
			@(posedge clk);
		while (due_results.size() != 0);
	endtask

	task automatic random_phase(input int target);
		int sent;
		int kind;
		int len;
		int bad_at;
		int k;
		sent = 0;
		while (sent < target) begin
			kind = $urandom_range(99);
			if (kind < 45) begin
				// full group of digits, a blank now and then
				for (k = 0; k < 5; k++) begin
					if ($urandom_range(7) == 0) begin
						send_req(plain(pick_blank(), 1'b0));
						sent++;
					end
					send_req(plain(pick_digit(), 1'b0));
				end
				sent += 5;
			end else if (kind < 57) begin
				send_req(plain(a85_pkg::CH_ZERO, 1'b0));
				sent++;
			end else if (kind < 75) begin
				// partial group closed by a flush
				len = $urandom_range(4, 1);
				repeat (len)
					send_req(plain(pick_digit(), 1'b0));
				send_req(plain(8'($urandom_range(255)), 1'b1));
				sent += len + 1;
			end else if (kind < 87) begin
				// broken group: one bad character, cut short by 'z' or a flush if under five
				len    = $urandom_range(5, 1);
				bad_at = $urandom_range(len - 1, 0);
				for (k = 0; k < len; k++)
					send_req(plain((k == bad_at) ? pick_bad() : pick_digit(), 1'b0));
				sent += len;
				if (len < 5) begin
					if ($urandom_range(1) == 0)
						send_req(plain(a85_pkg::CH_ZERO, 1'b0));
					else
						send_req(plain(8'($urandom_range(255)), 1'b1));
					sent++;
				end
			end else begin
				// raw noise
				send_req(plain(8'($urandom_range(255)), $urandom_range(4) == 0));
				sent++;
			end
		end
	endtask

	function automatic void report_mismatch(input string field, input int e, input int a);
		errors++;
		$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, e, a);
	endfunction

	// Result side: check popped results, then decide on the next pop
	initial begin
		a85_pkg::out_item_t want;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got %0h/%0d/%0b",
						$time, result.data_byte, result.status, result.last);
				end else begin
					want = due_results.pop_front();
					if (result.data_byte !== want.data_byte)
						report_mismatch("data_byte", want.data_byte, result.data_byte);
					if (result.status !== want.status)
						report_mismatch("status", want.status, result.status);
					if (result.last !== want.last)
						report_mismatch("last", want.last, result.last);
				end
			end
			if (rcv_hold > 0) begin
				rcv_hold--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	// Watchdog on cycles with no request and no result moving
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	// Stimulus
	initial begin
		int r;
		clear_group();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle_pct = 12;
		rcv_idle_pct = 52;
		for (r = 0; r < N_DIRECTED; r++)
			send_req(DIRECTED_ROWS[r]);
		drain();

		// long result stall while requests keep coming, to back up the queue
		rcv_hold = LONG_HOLD;
		random_phase(120);
		drain();

		snd_idle_pct = 52;
		rcv_idle_pct = 12;
		random_phase(120);
		drain();

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		random_phase(120);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (due_results.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, due_results.size());
		end
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: ascii85_decoder.f
design/a85_pkg.sv
design/a85_front.sv
design/a85_jobq.sv
design/a85_back.sv
design/ascii85_decoder.sv
dv/tb_ascii85_decoder.sv
